### rtl/wlrgb_pkg.sv
// shared constants, types and the color table for the wavelength to linear rgb pipeline
package wlrgb_pkg;

    localparam int TABLE_ENTRIES = 95;
    localparam int CIE_ROWS      = 95;
    localparam int CIE_Z_ROWS    = 58;

    localparam int WL_W   = 16;
    localparam int OUT_W  = 24;
    localparam int Q6_SH  = 6;
    localparam int FRAC_Q = 20;

    localparam int LO_Q6 = 360 << Q6_SH;
    localparam int HI_Q6 = 830 << Q6_SH;
    localparam int SPAN  = HI_Q6 - LO_Q6;

    localparam int W_W   = $clog2(SPAN + 1);
    localparam int D_W   = W_W;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    localparam longint unsigned P_MAX = longint'(SPAN) * longint'(TABLE_ENTRIES - 1);
    localparam int P_W  = $clog2(P_MAX + 1);
    localparam int KP   = P_W + 1;
    localparam longint unsigned RP = (64'd1 << KP) / SPAN;
    localparam int RP_W = $clog2(RP + 1);

    localparam int RGB_W = 46;
    localparam int LO_W  = 23;
    localparam int HI_W  = RGB_W - LO_W;
    localparam int HP_W  = HI_W + W_W + 1;
    localparam int LP_W  = LO_W + W_W;
    localparam int S_W   = HP_W + 1 + LO_W;

    localparam int DEN_SH  = FRAC_Q + Q6_SH;
    localparam int DEN_ODD = SPAN / 64;
    localparam longint unsigned RND   = longint'(DEN_ODD / 2) << DEN_SH;
    localparam longint unsigned T_CAP = longint'(DEN_ODD) << (OUT_W - 1);
    localparam int T_W  = $clog2(T_CAP + 1);
    localparam longint unsigned RQ = (64'd1 << T_W) / DEN_ODD;
    localparam int RQ_W = $clog2(RQ + 1);
    localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;

    localparam longint unsigned E12 = 64'd1000000000000;
    localparam longint          E6  = 64'sd1000000;

    typedef logic [2:0][RGB_W-1:0] t_rgb_row;
    typedef logic [TABLE_ENTRIES-1:0][2:0][RGB_W-1:0] t_rgb_tab;

    typedef struct packed {
        logic             in_range;
        logic [IDX_W-1:0] idx;
        logic [W_W-1:0]   frac;
    } t_idx_bus;

    typedef struct packed {
        logic               in_range;
        logic [2:0][S_W-1:0] sum;
    } t_sum_bus;

    // cie 1931 x, y, z in units of 1e-12, 5 nm steps from 360 nm
    localparam longint unsigned CIE_X_E12 [CIE_ROWS] = '{
        64'd129900000, 64'd232100000, 64'd414900000, 64'd741600000,
        64'd1368000000, 64'd2236000000, 64'd4243000000, 64'd7650000000,
        64'd14310000000, 64'd23190000000, 64'd43510000000, 64'd77630000000,
        64'd134380000000, 64'd214770000000, 64'd283900000000, 64'd328500000000,
        64'd348280000000, 64'd348060000000, 64'd336200000000, 64'd318700000000,
        64'd290800000000, 64'd251100000000, 64'd195360000000, 64'd142100000000,
        64'd95640000000, 64'd57950010000, 64'd32010000000, 64'd14700000000,
        64'd4900000000, 64'd2400000000, 64'd9300000000, 64'd29100000000,
        64'd63270000000, 64'd109600000000, 64'd165500000000, 64'd225749900000,
        64'd290400000000, 64'd359700000000, 64'd433449900000, 64'd512050100000,
        64'd594500000000, 64'd678400000000, 64'd762100000000, 64'd842500000000,
        64'd916300000000, 64'd978600000000, 64'd1026300000000, 64'd1056700000000,
        64'd1062200000000, 64'd1045600000000, 64'd1002600000000, 64'd938400000000,
        64'd854449900000, 64'd751400000000, 64'd642400000000, 64'd541900000000,
        64'd447900000000, 64'd360800000000, 64'd283500000000, 64'd218700000000,
        64'd164900000000, 64'd121200000000, 64'd87400000000, 64'd63600000000,
        64'd46770000000, 64'd32900000000, 64'd22700000000, 64'd15840000000,
        64'd11359160000, 64'd8110916000, 64'd5790346000, 64'd4109457000,
        64'd2899327000, 64'd2049190000, 64'd1439971000, 64'd999949300,
        64'd690078600, 64'd476021300, 64'd332301100, 64'd234826100,
        64'd166150500, 64'd117413000, 64'd83075270, 64'd58706520,
        64'd41509940, 64'd29353260, 64'd20673830, 64'd14559770,
        64'd10253980, 64'd7221456, 64'd5085868, 64'd3581652,
        64'd2522525, 64'd1776509, 64'd1251141
    };

    localparam longint unsigned CIE_Y_E12 [CIE_ROWS] = '{
        64'd3917000, 64'd6965000, 64'd12390000, 64'd22020000,
        64'd39000000, 64'd64000000, 64'd120000000, 64'd217000000,
        64'd396000000, 64'd640000000, 64'd1210000000, 64'd2180000000,
        64'd4000000000, 64'd7300000000, 64'd11600000000, 64'd16840000000,
        64'd23000000000, 64'd29800000000, 64'd38000000000, 64'd48000000000,
        64'd60000000000, 64'd73900000000, 64'd90980000000, 64'd112600000000,
        64'd139020000000, 64'd169300000000, 64'd208020000000, 64'd258600000000,
        64'd323000000000, 64'd407300000000, 64'd503000000000, 64'd608200000000,
        64'd710000000000, 64'd793200000000, 64'd862000000000, 64'd914850100000,
        64'd954000000000, 64'd980300000000, 64'd994950100000, 64'd1000000000000,
        64'd995000000000, 64'd978600000000, 64'd952000000000, 64'd915400000000,
        64'd870000000000, 64'd816300000000, 64'd757000000000, 64'd694900000000,
        64'd631000000000, 64'd566800000000, 64'd503000000000, 64'd441200000000,
        64'd381000000000, 64'd321000000000, 64'd265000000000, 64'd217000000000,
        64'd175000000000, 64'd138200000000, 64'd107000000000, 64'd81600000000,
        64'd61000000000, 64'd44580000000, 64'd32000000000, 64'd23200000000,
        64'd17000000000, 64'd11920000000, 64'd8210000000, 64'd5723000000,
        64'd4102000000, 64'd2929000000, 64'd2091000000, 64'd1484000000,
        64'd1047000000, 64'd740000000, 64'd520000000, 64'd361100000,
        64'd249200000, 64'd171900000, 64'd120000000, 64'd84800000,
        64'd60000000, 64'd42400000, 64'd30000000, 64'd21200000,
        64'd14990000, 64'd10600000, 64'd7465700, 64'd5257800,
        64'd3702900, 64'd2607800, 64'd1836600, 64'd1293400,
        64'd910930, 64'd641530, 64'd451810
    };

    // z is zero past the listed rows
    localparam longint unsigned CIE_Z_E12 [CIE_Z_ROWS] = '{
        64'd606100000, 64'd1086000000, 64'd1946000000, 64'd3486000000,
        64'd6450001000, 64'd10549990000, 64'd20050010000, 64'd36210000000,
        64'd67850010000, 64'd110200000000, 64'd207400000000, 64'd371300000000,
        64'd645600000000, 64'd1039050100000, 64'd1385600000000, 64'd1622960000000,
        64'd1747060000000, 64'd1782600000000, 64'd1772110000000, 64'd1744100000000,
        64'd1669200000000, 64'd1528100000000, 64'd1287640000000, 64'd1041900000000,
        64'd812950100000, 64'd616200000000, 64'd465180000000, 64'd353300000000,
        64'd272000000000, 64'd212300000000, 64'd158200000000, 64'd111700000000,
        64'd78249990000, 64'd57250010000, 64'd42160000000, 64'd29840000000,
        64'd20300000000, 64'd13400000000, 64'd8749999000, 64'd5749999000,
        64'd3900000000, 64'd2749999000, 64'd2100000000, 64'd1800000000,
        64'd1650001000, 64'd1400000000, 64'd1100000000, 64'd1000000000,
        64'd800000000, 64'd600000000, 64'd340000000, 64'd240000000,
        64'd190000000, 64'd100000000, 64'd49999990, 64'd30000000,
        64'd20000000, 64'd10000000
    };

    // bt.709 xyz to rgb matrix in units of 1e-6
    localparam longint MAT_E6 [3][3] = '{
        '{3240479, -1537150, -498535},
        '{-969256, 1875991, 41556},
        '{55648, -204043, 1057311}
    };

    function automatic longint unsigned cie_e12(input int comp, input int row);
        longint unsigned v;
        v = 64'd0;
        if (row < CIE_ROWS) begin
            case (comp)
                0:       v = CIE_X_E12[row];
                1:       v = CIE_Y_E12[row];
                default: begin
                    if (row < CIE_Z_ROWS) begin
                        v = CIE_Z_E12[row];
                    end
                end
            endcase
        end
        return v;
    endfunction

    function automatic longint rom_q20(input int comp, input int row);
        return longint'((cie_e12(comp, row) * 64'd1048576 + E12 / 2) / E12);
    endfunction

    function automatic longint mat_q20(input int r, input int c);
        longint v;
        v = MAT_E6[r][c] * 64'sd1048576;
        if (v >= 0) begin
            return (v + E6 / 2) / E6;
        end
        return -((-v + E6 / 2) / E6);
    endfunction

    // matrix applied to every table row ahead of time, exact in q40
    function automatic t_rgb_tab build_rgb_tab();
        t_rgb_tab tab;
        longint   acc;
        for (int row = 0; row < TABLE_ENTRIES; row++) begin
            for (int r = 0; r < 3; r++) begin
                acc = 0;
                for (int c = 0; c < 3; c++) begin
                    acc = acc + mat_q20(r, c) * rom_q20(c, row);
                end
                tab[row][r] = RGB_W'(acc);
            end
        end
        return tab;
    endfunction

    localparam t_rgb_tab RGB_TAB = build_rgb_tab();

endpackage

### rtl/wlrgb_index.sv
// range check, table position and interpolation weight, three pipeline stages
module wlrgb_index (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [wlrgb_pkg::WL_W-1:0]       i_wavelength,
    output logic                             o_valid,
    input  logic                             i_stall,
    output wlrgb_pkg::t_idx_bus              o_bus
);

    logic [2:0] r_vld;
    logic [2:0] w_rdy;

    logic                           n_s1_inr;
    logic                           r_s1_inr;
    logic [wlrgb_pkg::P_W-1:0]      n_s1_p;
    logic [wlrgb_pkg::P_W-1:0]      r_s1_p;
    logic [wlrgb_pkg::D_W-1:0]      w_d;

    logic [wlrgb_pkg::P_W+wlrgb_pkg::RP_W-1:0] w_prod;
    logic [wlrgb_pkg::IDX_W-1:0]    n_s2_q;
    logic [wlrgb_pkg::IDX_W-1:0]    r_s2_q;
    logic [wlrgb_pkg::P_W-1:0]      r_s2_p;
    logic                           r_s2_inr;

    logic [wlrgb_pkg::P_W-1:0]      w_rem;
    logic [wlrgb_pkg::IDX_W-1:0]    w_q;
    wlrgb_pkg::t_idx_bus            n_s3;
    wlrgb_pkg::t_idx_bus            r_s3;

    assign w_rdy[2] = !r_vld[2] || !i_stall;
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];
    assign o_stall  = !w_rdy[0];
    assign o_valid  = r_vld[2];
    assign o_bus    = r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (w_rdy[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    always_comb begin
        n_s1_inr = (i_wavelength >= wlrgb_pkg::WL_W'(wlrgb_pkg::LO_Q6)) &&
                   (i_wavelength <= wlrgb_pkg::WL_W'(wlrgb_pkg::HI_Q6));
        w_d      = n_s1_inr ?
                   wlrgb_pkg::D_W'(i_wavelength - wlrgb_pkg::WL_W'(wlrgb_pkg::LO_Q6)) : '0;
        n_s1_p   = wlrgb_pkg::P_W'(w_d) *
                   wlrgb_pkg::P_W'(wlrgb_pkg::TABLE_ENTRIES - 1);
    end

    // quotient estimate by reciprocal, low by at most one
    always_comb begin
        w_prod = (wlrgb_pkg::P_W + wlrgb_pkg::RP_W)'(r_s1_p) *
                 (wlrgb_pkg::P_W + wlrgb_pkg::RP_W)'(wlrgb_pkg::RP);
        n_s2_q = wlrgb_pkg::IDX_W'(w_prod >> wlrgb_pkg::KP);
    end

    always_comb begin
        w_rem = r_s2_p - wlrgb_pkg::P_W'(r_s2_q) * wlrgb_pkg::P_W'(wlrgb_pkg::SPAN);
        w_q   = r_s2_q;
        if (w_rem >= wlrgb_pkg::P_W'(wlrgb_pkg::SPAN)) begin
            w_q   = r_s2_q + wlrgb_pkg::IDX_W'(1);
            w_rem = w_rem - wlrgb_pkg::P_W'(wlrgb_pkg::SPAN);
        end
        n_s3.in_range = r_s2_inr;
        // top end of the range uses the last pair at full upper weight
        if (w_q == wlrgb_pkg::IDX_W'(wlrgb_pkg::TABLE_ENTRIES - 1)) begin
            n_s3.idx  = wlrgb_pkg::IDX_W'(wlrgb_pkg::TABLE_ENTRIES - 2);
            n_s3.frac = wlrgb_pkg::W_W'(wlrgb_pkg::SPAN);
        end else begin
            n_s3.idx  = w_q;
            n_s3.frac = wlrgb_pkg::W_W'(w_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1_inr <= n_s1_inr;
            r_s1_p   <= n_s1_p;
        end
        if (w_rdy[1]) begin
            r_s2_inr <= r_s1_inr;
            r_s2_p   <= r_s1_p;
            r_s2_q   <= n_s2_q;
        end
        if (w_rdy[2]) begin
            r_s3 <= n_s3;
        end
    end

endmodule

### rtl/wlrgb_interp.sv
// table read and linear blend of the two neighboring rgb rows, three pipeline stages
module wlrgb_interp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  wlrgb_pkg::t_idx_bus   i_bus,
    output logic                  o_valid,
    input  logic                  i_stall,
    output wlrgb_pkg::t_sum_bus   o_bus
);

    logic [2:0] r_vld;
    logic [2:0] w_rdy;

    logic [wlrgb_pkg::IDX_W-1:0]  w_idx1;
    wlrgb_pkg::t_rgb_row          n_s4_rgb0;
    wlrgb_pkg::t_rgb_row          n_s4_rgb1;
    wlrgb_pkg::t_rgb_row          r_s4_rgb0;
    wlrgb_pkg::t_rgb_row          r_s4_rgb1;
    logic [wlrgb_pkg::W_W-1:0]    n_s4_w0;
    logic [wlrgb_pkg::W_W-1:0]    r_s4_w0;
    logic [wlrgb_pkg::W_W-1:0]    r_s4_w1;
    logic                         r_s4_inr;

    logic signed [wlrgb_pkg::HP_W-1:0]  w_w0x;
    logic signed [wlrgb_pkg::HP_W-1:0]  w_w1x;
    logic [2:0][wlrgb_pkg::HP_W-1:0]    n_s5_hp0;
    logic [2:0][wlrgb_pkg::HP_W-1:0]    n_s5_hp1;
    logic [2:0][wlrgb_pkg::LP_W-1:0]    n_s5_lp0;
    logic [2:0][wlrgb_pkg::LP_W-1:0]    n_s5_lp1;
    logic [2:0][wlrgb_pkg::HP_W-1:0]    r_s5_hp0;
    logic [2:0][wlrgb_pkg::HP_W-1:0]    r_s5_hp1;
    logic [2:0][wlrgb_pkg::LP_W-1:0]    r_s5_lp0;
    logic [2:0][wlrgb_pkg::LP_W-1:0]    r_s5_lp1;
    logic                               r_s5_inr;

    wlrgb_pkg::t_sum_bus          n_s6;
    wlrgb_pkg::t_sum_bus          r_s6;

    assign w_rdy[2] = !r_vld[2] || !i_stall;
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];
    assign o_stall  = !w_rdy[0];
    assign o_valid  = r_vld[2];
    assign o_bus    = r_s6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (w_rdy[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    always_comb begin
        w_idx1    = i_bus.idx + wlrgb_pkg::IDX_W'(1);
        n_s4_rgb0 = wlrgb_pkg::RGB_TAB[i_bus.idx];
        n_s4_rgb1 = wlrgb_pkg::RGB_TAB[w_idx1];
        n_s4_w0   = wlrgb_pkg::W_W'(wlrgb_pkg::SPAN) - i_bus.frac;
    end

    // each 46-bit row value is split into a signed high and an unsigned low half
    assign w_w0x = wlrgb_pkg::HP_W'({1'b0, r_s4_w0});
    assign w_w1x = wlrgb_pkg::HP_W'({1'b0, r_s4_w1});

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_s5_hp0[c] = wlrgb_pkg::HP_W'(
                wlrgb_pkg::HP_W'($signed(r_s4_rgb0[c][wlrgb_pkg::RGB_W-1:wlrgb_pkg::LO_W]))
                * w_w0x);
            n_s5_hp1[c] = wlrgb_pkg::HP_W'(
                wlrgb_pkg::HP_W'($signed(r_s4_rgb1[c][wlrgb_pkg::RGB_W-1:wlrgb_pkg::LO_W]))
                * w_w1x);
            n_s5_lp0[c] = wlrgb_pkg::LP_W'(r_s4_rgb0[c][wlrgb_pkg::LO_W-1:0]) *
                          wlrgb_pkg::LP_W'(r_s4_w0);
            n_s5_lp1[c] = wlrgb_pkg::LP_W'(r_s4_rgb1[c][wlrgb_pkg::LO_W-1:0]) *
                          wlrgb_pkg::LP_W'(r_s4_w1);
        end
    end

    always_comb begin
        n_s6.in_range = r_s5_inr;
        for (int c = 0; c < 3; c++) begin
            n_s6.sum[c] = ((wlrgb_pkg::S_W'($signed(r_s5_hp0[c])) +
                            wlrgb_pkg::S_W'($signed(r_s5_hp1[c]))) << wlrgb_pkg::LO_W) +
                          wlrgb_pkg::S_W'(r_s5_lp0[c]) + wlrgb_pkg::S_W'(r_s5_lp1[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s4_rgb0 <= n_s4_rgb0;
            r_s4_rgb1 <= n_s4_rgb1;
            r_s4_w0   <= n_s4_w0;
            r_s4_w1   <= i_bus.frac;
            r_s4_inr  <= i_bus.in_range;
        end
        if (w_rdy[1]) begin
            r_s5_hp0 <= n_s5_hp0;
            r_s5_hp1 <= n_s5_hp1;
            r_s5_lp0 <= n_s5_lp0;
            r_s5_lp1 <= n_s5_lp1;
            r_s5_inr <= r_s4_inr;
        end
        if (w_rdy[2]) begin
            r_s6 <= n_s6;
        end
    end

endmodule

### rtl/wlrgb_scale.sv
// rounding division to q4.20, saturation and range masking, three pipeline stages
module wlrgb_scale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  wlrgb_pkg::t_sum_bus                  i_bus,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [wlrgb_pkg::OUT_W-1:0]   o_red,
    output logic signed [wlrgb_pkg::OUT_W-1:0]   o_green,
    output logic signed [wlrgb_pkg::OUT_W-1:0]   o_blue,
    output logic                                 o_in_range
);

    logic [2:0] r_vld;
    logic [2:0] w_rdy;

    logic [2:0][wlrgb_pkg::S_W-1:0]   w_mag;
    logic [2:0][wlrgb_pkg::S_W-1:0]   w_tr;
    logic [2:0]                       n_s7_neg;
    logic [2:0][wlrgb_pkg::T_W-1:0]   n_s7_t;
    logic [2:0]                       r_s7_neg;
    logic [2:0][wlrgb_pkg::T_W-1:0]   r_s7_t;
    logic                             r_s7_inr;

    logic [2:0][wlrgb_pkg::T_W+wlrgb_pkg::RQ_W-1:0] w_prod;
    logic [2:0][wlrgb_pkg::OUT_W-1:0] n_s8_q;
    logic [2:0][wlrgb_pkg::OUT_W-1:0] r_s8_q;
    logic [2:0][wlrgb_pkg::T_W-1:0]   r_s8_t;
    logic [2:0]                       r_s8_neg;
    logic                             r_s8_inr;

    logic [2:0][wlrgb_pkg::T_W-1:0]   w_rem;
    logic [2:0][wlrgb_pkg::OUT_W-1:0] w_qf;
    logic [2:0][wlrgb_pkg::OUT_W-1:0] n_s9_out;
    logic [2:0][wlrgb_pkg::OUT_W-1:0] r_s9_out;
    logic                             r_s9_inr;

    assign w_rdy[2] = !r_vld[2] || !i_stall;
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];
    assign o_stall  = !w_rdy[0];
    assign o_valid  = r_vld[2];

    assign o_red      = r_s9_out[0];
    assign o_green    = r_s9_out[1];
    assign o_blue     = r_s9_out[2];
    assign o_in_range = r_s9_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (w_rdy[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    // magnitude, half-up rounding and the power-of-two part of the divisor
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_s7_neg[c] = i_bus.sum[c][wlrgb_pkg::S_W-1];
            w_mag[c]    = n_s7_neg[c] ? (wlrgb_pkg::S_W'(0) - i_bus.sum[c]) : i_bus.sum[c];
            w_tr[c]     = (w_mag[c] + wlrgb_pkg::S_W'(wlrgb_pkg::RND)) >> wlrgb_pkg::DEN_SH;
            n_s7_t[c]   = (w_tr[c] >= wlrgb_pkg::S_W'(wlrgb_pkg::T_CAP)) ?
                          wlrgb_pkg::T_W'(wlrgb_pkg::T_CAP) : wlrgb_pkg::T_W'(w_tr[c]);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_prod[c] = (wlrgb_pkg::T_W + wlrgb_pkg::RQ_W)'(r_s7_t[c]) *
                        (wlrgb_pkg::T_W + wlrgb_pkg::RQ_W)'(wlrgb_pkg::RQ);
            n_s8_q[c] = wlrgb_pkg::OUT_W'(w_prod[c] >> wlrgb_pkg::T_W);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_rem[c] = r_s8_t[c] - wlrgb_pkg::T_W'(r_s8_q[c]) *
                       wlrgb_pkg::T_W'(wlrgb_pkg::DEN_ODD);
            w_qf[c]  = (w_rem[c] >= wlrgb_pkg::T_W'(wlrgb_pkg::DEN_ODD)) ?
                       r_s8_q[c] + wlrgb_pkg::OUT_W'(1) : r_s8_q[c];
            if (!r_s8_inr) begin
                n_s9_out[c] = '0;
            end else if (r_s8_neg[c]) begin
                n_s9_out[c] = wlrgb_pkg::OUT_W'(0) - w_qf[c];
            end else if (w_qf[c] > wlrgb_pkg::OUT_W'(wlrgb_pkg::OUT_MAX)) begin
                n_s9_out[c] = wlrgb_pkg::OUT_W'(wlrgb_pkg::OUT_MAX);
            end else begin
                n_s9_out[c] = w_qf[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s7_neg <= n_s7_neg;
            r_s7_t   <= n_s7_t;
            r_s7_inr <= i_bus.in_range;
        end
        if (w_rdy[1]) begin
            r_s8_q   <= n_s8_q;
            r_s8_t   <= r_s7_t;
            r_s8_neg <= r_s7_neg;
            r_s8_inr <= r_s7_inr;
        end
        if (w_rdy[2]) begin
            r_s9_out <= n_s9_out;
            r_s9_inr <= r_s8_inr;
        end
    end

endmodule

### rtl/wavelength_to_linear_rgb.sv
// top level: wavelength in, linear rec.709 rgb out through a nine-stage pipeline
//
// one request on the input channel carries i_wavelength (unsigned q10.6 nm);
// one result comes out on the output channel per request, in order, with
// o_red, o_green, o_blue (signed q4.20, saturated) and o_in_range.
// a request is taken at a rising edge with i_valid high and o_stall low;
// a result is taken at a rising edge with o_valid high and i_stall low.
// depth: nine register stages lie between the input and output channels.
// throughput: one request per cycle while i_stall is low; the two color-table
// reads happen in one stage and no stage holds two multiplies in series.
// each stage advances when the stage after it is empty or moving, so bubbles
// close up and requests keep being taken while a finished result waits.
// when i_stall holds, the pipeline fills and o_stall goes high once all nine
// stages carry a request; held results do not change.
// synchronous active-low reset clears all valid bits; no table fill is needed.
module wavelength_to_linear_rgb (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [wlrgb_pkg::WL_W-1:0]           i_wavelength,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [wlrgb_pkg::OUT_W-1:0]   o_red,
    output logic signed [wlrgb_pkg::OUT_W-1:0]   o_green,
    output logic signed [wlrgb_pkg::OUT_W-1:0]   o_blue,
    output logic                                 o_in_range
);

    logic                  w_idx_vld;
    logic                  w_idx_stall;
    wlrgb_pkg::t_idx_bus   w_idx_bus;
    logic                  w_sum_vld;
    logic                  w_sum_stall;
    wlrgb_pkg::t_sum_bus   w_sum_bus;

    wlrgb_index u_index (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_wavelength (i_wavelength),
        .o_valid      (w_idx_vld),
        .i_stall      (w_idx_stall),
        .o_bus        (w_idx_bus)
    );

    wlrgb_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_idx_vld),
        .o_stall (w_idx_stall),
        .i_bus   (w_idx_bus),
        .o_valid (w_sum_vld),
        .i_stall (w_sum_stall),
        .o_bus   (w_sum_bus)
    );

    wlrgb_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_sum_vld),
        .o_stall    (w_sum_stall),
        .i_bus      (w_sum_bus),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue),
        .o_in_range (o_in_range)
    );

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_range |-> o_red == '0 && o_green == '0 && o_blue == '0)
        else $error("out of range result is not zero");

    a_free_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output side is free");

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_idx_vld |-> w_idx_bus.frac <= wlrgb_pkg::W_W'(wlrgb_pkg::SPAN))
        else $error("interpolation weight above span");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_idx_vld |->
            w_idx_bus.idx <= wlrgb_pkg::IDX_W'(wlrgb_pkg::TABLE_ENTRIES - 2))
        else $error("table index past last pair");

endmodule
